// ===== hdl/sms_pkg.sv =====
package sms_pkg;

  localparam int ValueWidth = 64;

  // Maps a binary64 pattern to an unsigned key whose order is numeric order.
  // Both zeros map to the same key, so they compare equal.
  function automatic logic [ValueWidth-1:0] order_key(input logic [ValueWidth-1:0] bits);
    logic [ValueWidth-1:0] key;
    if (bits[ValueWidth-2:0] == '0) begin
      key = {1'b1, {(ValueWidth-1){1'b0}}};
    end else if (bits[ValueWidth-1]) begin
      key = ~bits;
    end else begin
      key = {1'b1, bits[ValueWidth-2:0]};
    end
    return key;
  endfunction

endpackage

// ===== hdl/stable_merge_sorter_core.sv =====
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+------------------------------------
// input    | value[63:0], last             | start high while busy low
// result   | value_res[63:0], last_res,    | res_valid high for one cycle,
//          | overflow                      | taken at the edge that ends it
//
// A non-last input transaction is written into bank A without leaving idle,
// so busy stays low. A last one starts the sort: each of the ceil(log2(n))
// merge passes moves every element through the shared comparator in a
// read-address step (S_MREAD) and a compare-and-write step (S_MWRITE); each
// run opens with a setup step and a pass closes through a final setup check
// and S_PASS_END. The emit phase then reads each element through an address,
// a read-wait and a strobe step. busy stays high through sort and emit. Reset
// clears the count, the overflow flag and the sequencer; the stores are not
// cleared since only loaded entries are read. The receiver cannot stall results.
module stable_merge_sorter_core
  import sms_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value,
  input  logic                  last,
  output logic                  res_valid,
  output logic [ValueWidth-1:0] value_res,
  output logic                  last_res,
  output logic                  overflow
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Run widths and run bounds may reach 2*CAPACITY.
  localparam int WW = $clog2(2 * CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN_SETUP, S_MREAD, S_MWRITE, S_PASS_END, S_EREAD, S_EWAIT, S_EOUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic          ovf_seen;
  // Which store currently holds the source runs (0: bank A).
  logic          src_sel;
  logic [WW-1:0] width, lo, mid, hi, a, b;
  logic [CW-1:0] k;

  // Two banks; each has one write and one registered read port per operand.
  logic           we_a, we_b;
  logic [AW-1:0]  waddr;
  logic [ValueWidth-1:0] wdata;
  logic [AW-1:0]  raddr_x, raddr_y;
  logic [ValueWidth-1:0] ax, ay, bx, by;

  // Each bank is two RAM copies so that two operands can be read per cycle.
  sms_ram #(.Width(ValueWidth), .Depth(CAPACITY)) u_ax (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr_x), .rdata(ax));
  sms_ram #(.Width(ValueWidth), .Depth(CAPACITY)) u_ay (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr_y), .rdata(ay));
  sms_ram #(.Width(ValueWidth), .Depth(CAPACITY)) u_bx (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr_x), .rdata(bx));
  sms_ram #(.Width(ValueWidth), .Depth(CAPACITY)) u_by (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr_y), .rdata(by));

  logic [ValueWidth-1:0] xv, yv;
  logic a_ok, b_ok, take_a;
  logic [WW-1:0] count_w, lo_next, mid_c, hi_c;

  assign xv      = src_sel ? bx : ax;
  assign yv      = src_sel ? by : ay;
  assign a_ok    = (a < mid);
  assign b_ok    = (b < hi);
  // Shared comparator: the earlier run wins ties, which keeps the sort stable.
  assign take_a  = a_ok && (!b_ok || (order_key(xv) <= order_key(yv)));
  assign count_w = WW'(count);
  assign mid_c   = ((lo + width) > count_w) ? count_w : (lo + width);
  assign hi_c    = ((lo + (width << 1)) > count_w) ? count_w : (lo + (width << 1));
  assign lo_next = lo + (width << 1);

  assign busy = (state != S_IDLE);

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr   = AW'(k);
    wdata   = take_a ? xv : yv;
    raddr_x = AW'(a);
    raddr_y = AW'(b);
    case (state)
      S_IDLE: begin
        waddr = AW'(count);
        wdata = value;
        we_a  = start && (count < CW'(CAPACITY));
      end
      S_MWRITE: begin
        we_a = src_sel;
        we_b = !src_sel;
      end
      S_EREAD: begin
        raddr_x = AW'(k);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf_seen  <= 1'b0;
      res_valid <= 1'b0;
      src_sel   <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (count < CW'(CAPACITY)) begin
              count <= count + 1'b1;
            end else begin
              ovf_seen <= 1'b1;
            end
            if (last) begin
              if (count < CW'(CAPACITY)) begin
                count <= count + 1'b1;
              end
              width   <= WW'(1);
              lo      <= '0;
              src_sel <= 1'b0;
              state   <= S_PASS_END;
            end
          end
        end
        S_PASS_END: begin
          // Decide whether another merge pass is needed.
          if (width < count_w) begin
            lo    <= '0;
            state <= S_RUN_SETUP;
          end else begin
            k     <= '0;
            state <= S_EREAD;
          end
        end
        S_RUN_SETUP: begin
          if (lo < count_w) begin
            mid   <= mid_c;
            hi    <= hi_c;
            a     <= lo;
            b     <= mid_c;
            k     <= CW'(lo);
            state <= S_MREAD;
          end else begin
            src_sel <= !src_sel;
            width   <= width << 1;
            state   <= S_PASS_END;
          end
        end
        S_MREAD: begin
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          if (take_a) begin
            a <= a + 1'b1;
          end else begin
            b <= b + 1'b1;
          end
          k <= k + 1'b1;
          if (WW'(k) + 1'b1 == hi) begin
            lo    <= lo_next;
            state <= S_RUN_SETUP;
          end else begin
            state <= S_MREAD;
          end
        end
        S_EREAD: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          res_valid <= 1'b1;
          value_res <= xv;
          last_res  <= (k + 1'b1 == count);
          overflow  <= ovf_seen;
          state     <= S_EOUT;
        end
        S_EOUT: begin
          if (k + 1'b1 == count) begin
            count    <= '0;
            ovf_seen <= 1'b0;
            state    <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_EREAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("element count above capacity");
  // A result only comes out while the block is busy emitting.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> state == S_EOUT)
    else $error("result strobe outside emit");
  // The merge write index stays inside the current run.
  assert property (@(posedge clk) disable iff (rst)
    state == S_MWRITE |-> (WW'(k) < hi) && (a <= mid) && (b <= hi))
    else $error("merge index out of run");
  // After the final result the block is free again.
  assert property (@(posedge clk) disable iff (rst) res_valid && last_res |=> !busy)
    else $error("block still busy after last result");

endmodule

// ===== hdl/sms_ram.sv =====
module sms_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
